// ----- design/sbqs_pkg.sv -----
// Shared types, codes and constants of the sprite batch quad setup block.
package sbqs_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FLUSH_REQ,
    ST_FLUSH_BATCH,
    ST_SEARCH,
    ST_CHECK_SLOT,
    ST_FLUSH_SLOT,
    ST_ASSIGN,
    ST_MULT,
    ST_EMIT
  } state_e;

  localparam logic [1:0] REQ_SUBMIT = 2'd0;
  localparam logic [1:0] REQ_FLUSH  = 2'd1;
  localparam logic [1:0] REQ_BEGIN  = 2'd2;

  localparam logic REG_BATCH_LIMIT = 1'b0;
  localparam logic REG_SLOT_LIMIT  = 1'b1;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  localparam logic [10:0] BATCH_LIMIT_RESET = 11'd1000;
  localparam logic [3:0]  SLOT_LIMIT_RESET  = 4'd8;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [28:0] VMAX = 29'sd33554431;
  localparam logic signed [28:0] VMIN = -29'sd33554432;

  typedef struct packed {
    logic load;
    logic clr_cnt;
    logic emit_flush;
    logic flush_last;
    logic search_start;
    logic search_step;
    logic take_match;
    logic assign_slot;
    logic mul_step;
    logic emit_vert;
    logic inc_batch;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       tex_zero;
    logic       batch_full;
    logic       cnt_nonzero;
    logic       search_end;
    logic       match;
    logic       slots_full;
    logic       trig_done;
    logic       mul_last;
    logic       corner_last;
    logic       out_free;
  } status_t;

  // Arctangent of 2^-i in units of 2^32 per turn.
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ----- design/sbqs_ctrl.sv -----
// Controller state machine that sequences one request through the datapath.
module sbqs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sbqs_pkg::status_t status_i,
  output sbqs_pkg::cmd_t    cmd_o
);
  import sbqs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status_i.req == REQ_BEGIN) begin
          cmd_o.clr_cnt = 1'b1;
          state_d       = ST_IDLE;
        end else if (status_i.req == REQ_FLUSH) begin
          if (status_i.cnt_nonzero) begin
            state_d = ST_FLUSH_REQ;
          end else begin
            cmd_o.clr_cnt = 1'b1;
            state_d       = ST_IDLE;
          end
        end else if (status_i.req == REQ_SUBMIT && !status_i.tex_zero) begin
          if (status_i.batch_full && status_i.cnt_nonzero) begin
            state_d = ST_FLUSH_BATCH;
          end else begin
            cmd_o.clr_cnt      = status_i.batch_full;
            cmd_o.search_start = 1'b1;
            state_d            = ST_SEARCH;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FLUSH_REQ: begin
        if (status_i.out_free) begin
          cmd_o.emit_flush = 1'b1;
          cmd_o.flush_last = 1'b1;
          cmd_o.clr_cnt    = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_FLUSH_BATCH: begin
        if (status_i.out_free) begin
          cmd_o.emit_flush   = 1'b1;
          cmd_o.clr_cnt      = 1'b1;
          cmd_o.search_start = 1'b1;
          state_d            = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (status_i.search_end) begin
          state_d = ST_CHECK_SLOT;
        end else if (status_i.match) begin
          cmd_o.take_match = 1'b1;
          state_d          = ST_MULT;
        end else begin
          cmd_o.search_step = 1'b1;
        end
      end
      ST_CHECK_SLOT: begin
        if (status_i.slots_full && status_i.cnt_nonzero) begin
          state_d = ST_FLUSH_SLOT;
        end else begin
          cmd_o.clr_cnt = status_i.slots_full;
          state_d       = ST_ASSIGN;
        end
      end
      ST_FLUSH_SLOT: begin
        if (status_i.out_free) begin
          cmd_o.emit_flush = 1'b1;
          cmd_o.clr_cnt    = 1'b1;
          state_d          = ST_ASSIGN;
        end
      end
      ST_ASSIGN: begin
        cmd_o.assign_slot = 1'b1;
        state_d           = ST_MULT;
      end
      ST_MULT: begin
        if (status_i.trig_done) begin
          cmd_o.mul_step = 1'b1;
          if (status_i.mul_last) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_vert = 1'b1;
          if (status_i.corner_last) begin
            cmd_o.inc_batch = 1'b1;
            state_d         = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/sbqs_dpath.sv -----
// Datapath: counters, slot table, CORDIC unit, shared multiplier and result register.
module sbqs_dpath #(
  parameter int MAX_BATCH       = 1024,
  parameter int NUM_SLOTS       = 8,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sbqs_pkg::cmd_t      cmd_i,
  output sbqs_pkg::status_t   status_o,
  input  logic [10:0]         batch_limit_i,
  input  logic [3:0]          slot_limit_i,
  input  logic [1:0]          req_type_i,
  input  logic [31:0]         texture_id_i,
  input  logic signed [23:0]  pos_x_i,
  input  logic signed [23:0]  pos_y_i,
  input  logic [22:0]         size_w_i,
  input  logic [22:0]         size_h_i,
  input  logic [15:0]         angle_i,
  input  logic [7:0]          red_in_i,
  input  logic [7:0]          green_in_i,
  input  logic [7:0]          blue_in_i,
  input  logic [7:0]          alpha_in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                kind_o,
  output logic signed [25:0]  vert_x_o,
  output logic signed [25:0]  vert_y_o,
  output logic [1:0]          corner_o,
  output logic [7:0]          red_out_o,
  output logic [7:0]          green_out_o,
  output logic [7:0]          blue_out_o,
  output logic [7:0]          alpha_out_o,
  output logic [3:0]          slot_o,
  output logic [11:0]         vertex_number_o,
  output logic [10:0]         flushed_sprites_o,
  output logic                last_o
);
  import sbqs_pkg::*;

  localparam int SW  = $clog2(NUM_SLOTS + 1);
  localparam int IW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int ITW = $clog2(TRIG_ITERATIONS);

  // Latched request.
  logic [1:0]         req_q;
  logic [31:0]        tex_q;
  logic signed [23:0] px_q, py_q;
  logic [22:0]        w_q, h_q;
  logic [1:0]         quad_q;
  logic [7:0]         r_q, g_q, b_q, a_q;

  logic [10:0]   bs_q;
  logic [SW-1:0] su_q, idx_q, slot_q;
  logic [31:0]   table_q [NUM_SLOTS];

  logic signed [33:0] x_q, y_q;
  logic signed [32:0] z_q;
  logic [ITW-1:0]     it_q;
  logic               busy_q;

  logic [1:0]         mcnt_q, corner_q;
  logic signed [55:0] prod_q [4];

  logic out_valid_q, out_free;

  // Clamped limits.
  logic [12:0] lim_b, blim;
  logic [5:0]  lim_s, slim;

  always_comb begin
    lim_b = {2'b00, batch_limit_i};
    if (lim_b == 13'd0) begin
      blim = 13'd1;
    end else if (lim_b > 13'(MAX_BATCH)) begin
      blim = 13'(MAX_BATCH);
    end else begin
      blim = lim_b;
    end
    lim_s = {2'b00, slot_limit_i};
    if (lim_s == 6'd0) begin
      slim = 6'd1;
    end else if (lim_s > 6'(NUM_SLOTS)) begin
      slim = 6'(NUM_SLOTS);
    end else begin
      slim = lim_s;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    status_o             = '0;
    status_o.req         = req_q;
    status_o.tex_zero    = (tex_q == 32'd0);
    status_o.batch_full  = ({2'b00, bs_q} >= blim);
    status_o.cnt_nonzero = (bs_q != 11'd0) && (su_q != '0);
    status_o.search_end  = (idx_q >= su_q);
    status_o.match       = (table_q[idx_q[IW-1:0]] == tex_q);
    status_o.slots_full  = (6'(su_q) >= slim);
    status_o.trig_done   = !busy_q;
    status_o.mul_last    = (mcnt_q == 2'd3);
    status_o.corner_last = (corner_q == 2'd3);
    status_o.out_free    = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_type_i;
      tex_q  <= texture_id_i;
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      w_q    <= size_w_i;
      h_q    <= size_h_i;
      quad_q <= angle_i[15:14];
      r_q    <= red_in_i;
      g_q    <= green_in_i;
      b_q    <= blue_in_i;
      a_q    <= alpha_in_i;
    end
    if (cmd_i.assign_slot) begin
      table_q[su_q[IW-1:0]] <= tex_q;
    end
  end

  // Counters and search index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q     <= '0;
      su_q     <= '0;
      idx_q    <= '0;
      slot_q   <= '0;
      mcnt_q   <= '0;
      corner_q <= '0;
    end else begin
      if (cmd_i.clr_cnt) begin
        bs_q <= '0;
        su_q <= '0;
      end
      if (cmd_i.assign_slot) begin
        su_q   <= su_q + 1'b1;
        slot_q <= su_q;
      end
      if (cmd_i.inc_batch) begin
        bs_q <= bs_q + 11'd1;
      end
      if (cmd_i.search_start) begin
        idx_q <= '0;
      end else if (cmd_i.search_step) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.take_match) begin
        slot_q <= idx_q;
      end
      if (cmd_i.load) begin
        mcnt_q   <= '0;
        corner_q <= '0;
      end else begin
        if (cmd_i.mul_step) begin
          mcnt_q <= mcnt_q + 2'd1;
        end
        if (cmd_i.emit_vert) begin
          corner_q <= corner_q + 2'd1;
        end
      end
    end
  end

  // CORDIC: one rotation step a cycle, started by the input transfer.
  logic signed [33:0] dx, dy;
  logic signed [32:0] at;

  always_comb begin
    dx = y_q >>> it_q;
    dy = x_q >>> it_q;
    at = $signed({1'b0, atan_entry(5'(it_q))});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      it_q   <= '0;
    end else if (cmd_i.load) begin
      busy_q <= 1'b1;
      it_q   <= '0;
    end else if (busy_q) begin
      it_q <= it_q + 1'b1;
      if (it_q == ITW'(TRIG_ITERATIONS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= CORDIC_GAIN;
      y_q <= '0;
      z_q <= $signed({3'b000, angle_i[13:0], 16'h0000});
    end else if (busy_q) begin
      if (!z_q[32]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
  end

  logic signed [31:0] co, si;

  always_comb begin
    case (quad_q)
      2'd0: begin
        co = 32'(x_q);
        si = 32'(y_q);
      end
      2'd1: begin
        co = 32'(-y_q);
        si = 32'(x_q);
      end
      2'd2: begin
        co = 32'(-x_q);
        si = 32'(-y_q);
      end
      default: begin
        co = 32'(y_q);
        si = 32'(-x_q);
      end
    endcase
  end

  // Shared multiplier: hx*co, hy*si, hx*si, hy*co in turn.
  logic signed [23:0] ma;
  logic signed [31:0] mb;

  always_comb begin
    ma = mcnt_q[0] ? $signed({1'b0, h_q}) : $signed({1'b0, w_q});
    mb = (mcnt_q == 2'd1 || mcnt_q == 2'd2) ? si : co;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_step) begin
      prod_q[mcnt_q] <= ma * mb;
    end
  end

  // Corner sum, rounding and saturation.
  logic               sx, sy;
  logic signed [56:0] pa, pb, pc, pd, rx, ry;
  logic signed [25:0] cxv, cyv;
  logic signed [59:0] tx, ty;
  logic signed [28:0] qx, qy;
  logic signed [25:0] vx, vy;

  always_comb begin
    sx  = (corner_q == 2'd1) || (corner_q == 2'd2);
    sy  = corner_q[1];
    pa  = 57'(prod_q[0]);
    pb  = 57'(prod_q[1]);
    pc  = 57'(prod_q[2]);
    pd  = 57'(prod_q[3]);
    rx  = (sx ? pa : -pa) + (sy ? -pb : pb);
    ry  = (sx ? pc : -pc) + (sy ? pd : -pd);
    cxv = $signed({px_q[23], px_q, 1'b0}) + $signed({3'b000, w_q});
    cyv = $signed({py_q[23], py_q, 1'b0}) + $signed({3'b000, h_q});
    tx  = (60'(cxv) <<< 30) + 60'(rx) + (60'sd1 <<< 30);
    ty  = (60'(cyv) <<< 30) + 60'(ry) + (60'sd1 <<< 30);
    qx  = tx[59:31];
    qy  = ty[59:31];
    if (qx > VMAX) begin
      vx = 26'(VMAX);
    end else if (qx < VMIN) begin
      vx = 26'(VMIN);
    end else begin
      vx = 26'(qx);
    end
    if (qy > VMAX) begin
      vy = 26'(VMAX);
    end else if (qy < VMIN) begin
      vy = 26'(VMIN);
    end else begin
      vy = 26'(qy);
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_flush || cmd_i.emit_vert) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_flush) begin
      kind_o            <= KIND_FLUSH;
      vert_x_o          <= '0;
      vert_y_o          <= '0;
      corner_o          <= '0;
      red_out_o         <= '0;
      green_out_o       <= '0;
      blue_out_o        <= '0;
      alpha_out_o       <= '0;
      slot_o            <= 4'(su_q);
      vertex_number_o   <= '0;
      flushed_sprites_o <= bs_q;
      last_o            <= cmd_i.flush_last;
    end else if (cmd_i.emit_vert) begin
      kind_o            <= KIND_VERTEX;
      vert_x_o          <= vx;
      vert_y_o          <= vy;
      corner_o          <= corner_q;
      red_out_o         <= r_q;
      green_out_o       <= g_q;
      blue_out_o        <= b_q;
      alpha_out_o       <= a_q;
      slot_o            <= 4'(slot_q);
      vertex_number_o   <= 12'({bs_q, corner_q});
      flushed_sprites_o <= '0;
      last_o            <= (corner_q == 2'd3);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- design/sprite_batch_quad_setup.sv -----
// Top level of the sprite batch quad setup block: register port, controller and datapath.
//
//   channel   direction  handshake               payload
//   request   in         in_valid_i/in_stall_o   req_type_i .. alpha_in_i
//   result    out        out_valid_o/out_stall_i kind_o .. last_o
//   config    in         APB psel/penable/pready batch_limit (0x0), slot_limit (0x4)
//
// A submit runs through the CORDIC steps, the four multiplier products and the four result
// vertices before the next input is taken. The slot search and a forced flush run alongside
// the CORDIC steps while they are shorter than those.
// A begin returns to idle straight after decode, and so does a flush unless it first sends a flush result.
// Each result waits in the output register until the far side stops stalling.
// Reset clears the counters; the slot table needs no clearing pass.
module sprite_batch_quad_setup #(
  parameter int MAX_BATCH       = 1024,
  parameter int NUM_SLOTS       = 8,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [31:0]        texture_id_i,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [23:0] pos_y_i,
  input  logic [22:0]        size_w_i,
  input  logic [22:0]        size_h_i,
  input  logic [15:0]        angle_i,
  input  logic [7:0]         red_in_i,
  input  logic [7:0]         green_in_i,
  input  logic [7:0]         blue_in_i,
  input  logic [7:0]         alpha_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic signed [25:0] vert_x_o,
  output logic signed [25:0] vert_y_o,
  output logic [1:0]         corner_o,
  output logic [7:0]         red_out_o,
  output logic [7:0]         green_out_o,
  output logic [7:0]         blue_out_o,
  output logic [7:0]         alpha_out_o,
  output logic [3:0]         slot_o,
  output logic [11:0]        vertex_number_o,
  output logic [10:0]        flushed_sprites_o,
  output logic               last_o
);
  import sbqs_pkg::*;

  logic [10:0] batch_limit_q;
  logic [3:0]  slot_limit_q;
  cmd_t        cmd;
  status_t     status;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_limit_q <= BATCH_LIMIT_RESET;
      slot_limit_q  <= SLOT_LIMIT_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_BATCH_LIMIT) begin
        batch_limit_q <= pwdata[10:0];
      end else begin
        slot_limit_q <= pwdata[3:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_SLOT_LIMIT) ? {28'd0, slot_limit_q} : {21'd0, batch_limit_q};

  sbqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sbqs_dpath #(
    .MAX_BATCH       (MAX_BATCH),
    .NUM_SLOTS       (NUM_SLOTS),
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .batch_limit_i     (batch_limit_q),
    .slot_limit_i      (slot_limit_q),
    .req_type_i        (req_type_i),
    .texture_id_i      (texture_id_i),
    .pos_x_i           (pos_x_i),
    .pos_y_i           (pos_y_i),
    .size_w_i          (size_w_i),
    .size_h_i          (size_h_i),
    .angle_i           (angle_i),
    .red_in_i          (red_in_i),
    .green_in_i        (green_in_i),
    .blue_in_i         (blue_in_i),
    .alpha_in_i        (alpha_in_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .kind_o            (kind_o),
    .vert_x_o          (vert_x_o),
    .vert_y_o          (vert_y_o),
    .corner_o          (corner_o),
    .red_out_o         (red_out_o),
    .green_out_o       (green_out_o),
    .blue_out_o        (blue_out_o),
    .alpha_out_o       (alpha_out_o),
    .slot_o            (slot_o),
    .vertex_number_o   (vertex_number_o),
    .flushed_sprites_o (flushed_sprites_o),
    .last_o            (last_o)
  );

  // The last vertex of a sprite is always corner three.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_VERTEX) |-> (last_o == (corner_o == 2'd3)))
    else $error("vertex last flag does not match corner");

  // A flush result never reports an empty batch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_FLUSH) |-> (flushed_sprites_o != 11'd0 && slot_o != 4'd0))
    else $error("flush result for an empty batch");

  // The vertex number carries the corner in its low bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_VERTEX) |-> (vertex_number_o[1:0] == corner_o))
    else $error("vertex number and corner disagree");

endmodule
